FILE: design/bds_pkg.sv
package bds_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int CH_W       = 5;
    localparam int SUM_W      = 9;
    localparam int ENTRY_W    = 3 * SUM_W;
    localparam int PIX_W      = 16;
    localparam int SCALE_W    = 3;
    localparam int OW_W       = 11;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-1:0] ADDR_SCALE     = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_OUT_WIDTH = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RESET     = 3'd1;
    localparam logic [OW_W-1:0]    OUT_WIDTH_RESET = 11'd1024;

    // reciprocal of 9 for sums below 512: floor(x*57/512) == floor(x/9)
    localparam int RECIP9_MUL   = 57;
    localparam int RECIP9_SHIFT = 9;

    typedef logic [LINE_AW-1:0] col_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [1:0] {
        SC_1 = 2'd0,
        SC_2 = 2'd1,
        SC_3 = 2'd2,
        SC_4 = 2'd3
    } scale_code_t;

    typedef struct packed {
        col_t        addr;
        logic        zero;
        logic        emit;
        logic        row_end;
        logic        pass;
        scale_code_t scode;
    } ctl_t;

    function automatic logic [CH_W-1:0] avg_channel(input logic [SUM_W-1:0] sum,
                                                    input scale_code_t scode);
        logic [SUM_W+6:0] prod;
        logic [CH_W-1:0]  q;
        prod = (SUM_W+7)'(sum) * (SUM_W+7)'(RECIP9_MUL);
        case (scode)
            SC_2:    q = sum[CH_W+1:2];
            SC_3:    q = prod[RECIP9_SHIFT+CH_W-1:RECIP9_SHIFT];
            default: q = sum[CH_W+3:4];
        endcase
        return q;
    endfunction

endpackage

FILE: design/bds_line_mem.sv
module bds_line_mem (
    input  logic                 clk,
    input  logic                 we,
    input  bds_pkg::col_t        waddr,
    input  bds_pkg::entry_t      wdata,
    input  logic                 re,
    input  bds_pkg::col_t        raddr,
    output bds_pkg::entry_t      rdata
);

    bds_pkg::entry_t store_reg [bds_pkg::LINE_DEPTH];
    bds_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bds_pos_ctrl.sv
module bds_pos_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bds_pkg::SCALE_W-1:0]      scale,
    input  logic [bds_pkg::OW_W-1:0]         out_width,
    input  logic                             first,
    input  logic                             accept,
    output bds_pkg::ctl_t                    ctl
);

    bds_pkg::col_t out_col_reg, out_col_next;
    logic [1:0]    cib_reg, cib_next;
    logic [1:0]    rib_reg, rib_next;

    bds_pkg::scale_code_t scode;
    logic [1:0]           sm1;
    bds_pkg::col_t        wm1;
    bds_pkg::col_t        oc;
    logic [1:0]           cib;
    logic [1:0]           rib;
    logic                 last_col;
    logic                 last_row;
    logic                 at_end;

    always_comb
    begin
        case (scale)
            3'd0, 3'd1: scode = bds_pkg::SC_1;
            3'd2:       scode = bds_pkg::SC_2;
            3'd3:       scode = bds_pkg::SC_3;
            default:    scode = bds_pkg::SC_4;
        endcase
        sm1 = 2'(scode);

        if (out_width == '0)
            wm1 = '0;
        else if (32'(out_width) > 32'(bds_pkg::LINE_DEPTH))
            wm1 = bds_pkg::col_t'(bds_pkg::LINE_DEPTH - 1);
        else
            wm1 = bds_pkg::col_t'(out_width - 11'd1);

        oc  = first ? '0 : out_col_reg;
        cib = first ? '0 : cib_reg;
        rib = first ? '0 : rib_reg;
        if (oc > wm1)
            oc = wm1;
        if (cib > sm1)
            cib = sm1;
        if (rib > sm1)
            rib = sm1;

        last_col = (cib == sm1);
        last_row = (rib == sm1);
        at_end   = (oc == wm1);

        ctl.addr    = oc;
        ctl.zero    = (cib == 2'd0) && (rib == 2'd0);
        ctl.emit    = last_col && last_row;
        ctl.row_end = at_end;
        ctl.pass    = (scode == bds_pkg::SC_1);
        ctl.scode   = scode;

        out_col_next = oc;
        rib_next     = rib;
        cib_next     = cib + 2'd1;
        if (last_col)
        begin
            cib_next = '0;
            if (at_end)
            begin
                out_col_next = '0;
                rib_next     = last_row ? 2'd0 : rib + 2'd1;
            end
            else
            begin
                out_col_next = oc + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
        end
        else if (accept)
        begin
            out_col_reg <= out_col_next;
            cib_reg     <= cib_next;
            rib_reg     <= rib_next;
        end
    end

endmodule

FILE: design/bds_accum.sv
module bds_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bds_pkg::PIX_W-1:0]     pixel,
    input  bds_pkg::ctl_t                 ctl,
    output logic                          accept,
    output logic                          mem_we,
    output bds_pkg::col_t                 mem_waddr,
    output bds_pkg::entry_t               mem_wdata,
    input  bds_pkg::entry_t               mem_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bds_pkg::PIX_W-1:0]     out_pixel,
    output logic                          row_end
);

    localparam int SW = bds_pkg::SUM_W;
    localparam int CW = bds_pkg::CH_W;

    logic                          s1_valid_reg;
    bds_pkg::ctl_t                 s1_ctl_reg;
    logic [bds_pkg::PIX_W-1:0]     s1_pixel_reg;
    logic                          fwd_reg;
    bds_pkg::entry_t               fwd_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [bds_pkg::PIX_W-1:0]     out_pixel_reg;
    logic                          row_end_reg;

    bds_pkg::entry_t               entry;
    logic [SW-1:0]                 sum_b, sum_g, sum_r;
    bds_pkg::entry_t               new_entry;
    logic [bds_pkg::PIX_W-1:0]     result;
    logic                          has_result;
    logic                          s1_advance;
    logic                          out_taken;
    logic                          out_load;

    always_comb
    begin
        if (s1_ctl_reg.zero)
            entry = '0;
        else if (fwd_reg)
            entry = fwd_data_reg;
        else
            entry = mem_rdata;

        sum_b = entry[SW-1:0]      + SW'(s1_pixel_reg[CW-1:0]);
        sum_g = entry[2*SW-1:SW]   + SW'(s1_pixel_reg[2*CW-1:CW]);
        sum_r = entry[3*SW-1:2*SW] + SW'(s1_pixel_reg[3*CW-1:2*CW]);
        new_entry = {sum_r, sum_g, sum_b};

        if (s1_ctl_reg.pass)
            result = s1_pixel_reg;
        else
            result = {1'b1,
                      bds_pkg::avg_channel(sum_r, s1_ctl_reg.scode),
                      bds_pkg::avg_channel(sum_g, s1_ctl_reg.scode),
                      bds_pkg::avg_channel(sum_b, s1_ctl_reg.scode)};

        has_result = s1_ctl_reg.emit;
        out_taken  = out_valid_reg && !out_stall;
        s1_advance = !s1_valid_reg || !has_result || !out_valid_reg || !out_stall;
        out_load   = s1_valid_reg && s1_advance && has_result;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_taken)
            out_valid_next = 1'b0;
    end

    assign in_stall  = !s1_advance;
    assign accept    = in_valid && s1_advance;
    assign mem_we    = s1_valid_reg && s1_advance && !s1_ctl_reg.pass;
    assign mem_waddr = s1_ctl_reg.addr;
    assign mem_wdata = new_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_advance)
                s1_valid_reg <= in_valid;
            if (accept)
                fwd_reg <= mem_we && (s1_ctl_reg.addr == ctl.addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg   <= ctl;
            s1_pixel_reg <= pixel;
            fwd_data_reg <= new_entry;
        end
        if (out_load)
        begin
            out_pixel_reg <= result;
            row_end_reg   <= s1_ctl_reg.row_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign row_end   = row_end_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && has_result))
        else $error("stall without a full pipeline");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost");

    a_pass_always_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctl_reg.pass) |-> (s1_ctl_reg.emit && !mem_we))
        else $error("pass-through transaction without result");

endmodule

FILE: design/box_downscale_rgb555.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  pixel[15:0], first
// output    out        out_valid/ out_stall out_pixel[15:0], row_end
// config    in         APB write/read       scale @0x0, out_width @0x4
//
// One transaction per cycle unless in_stall; results pass stage one, then the output reg.
// Line store read is registered; a same-column write from stage one is forwarded.
// rst_n is asynchronous; line store contents are not cleared.
// in_stall rises only when a result waits in stage one and the output register is stalled.
module box_downscale_rgb555 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bds_pkg::APB_AW-1:0]     paddr,
    input  logic [bds_pkg::APB_DW-1:0]     pwdata,
    output logic [bds_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bds_pkg::PIX_W-1:0]      pixel,
    input  logic                           first,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bds_pkg::PIX_W-1:0]      out_pixel,
    output logic                           row_end
);

    logic [bds_pkg::SCALE_W-1:0] scale_reg;
    logic [bds_pkg::OW_W-1:0]    out_width_reg;
    logic                        cfg_wr;

    bds_pkg::ctl_t   ctl;
    logic            accept;
    logic            mem_we;
    bds_pkg::col_t   mem_waddr;
    bds_pkg::entry_t mem_wdata;
    bds_pkg::entry_t mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= bds_pkg::SCALE_RESET;
            out_width_reg <= bds_pkg::OUT_WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                bds_pkg::ADDR_SCALE:     scale_reg     <= pwdata[bds_pkg::SCALE_W-1:0];
                bds_pkg::ADDR_OUT_WIDTH: out_width_reg <= pwdata[bds_pkg::OW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            bds_pkg::ADDR_SCALE:     prdata = bds_pkg::APB_DW'(scale_reg);
            bds_pkg::ADDR_OUT_WIDTH: prdata = bds_pkg::APB_DW'(out_width_reg);
            default:                 prdata = '0;
        endcase
    end

    bds_pos_ctrl u_pos_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (scale_reg),
        .out_width (out_width_reg),
        .first     (first),
        .accept    (accept),
        .ctl       (ctl)
    );

    bds_line_mem u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (ctl.addr),
        .rdata (mem_rdata)
    );

    bds_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .ctl       (ctl),
        .accept    (accept),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel),
        .row_end   (row_end)
    );

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 150;
    localparam int WATCHDOG      = 3000;
    localparam int RANDOM_ITEMS  = 800;

    typedef struct packed {
        logic [bds_pkg::PIX_W-1:0] pix;
        logic                      first;
    } src_pix_t;

    typedef struct packed {
        logic [bds_pkg::PIX_W-1:0] pix;
        logic                      row_end;
    } dst_pix_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [bds_pkg::APB_AW-1:0] paddr = '0;
    logic [bds_pkg::APB_DW-1:0] pwdata = '0;
    logic [bds_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [bds_pkg::PIX_W-1:0]  pixel = '0;
    logic                       first = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [bds_pkg::PIX_W-1:0]  out_pixel;
    logic                       row_end;

    // shadow of the block's registers and state
    logic [bds_pkg::SCALE_W-1:0] cfg_scale = bds_pkg::SCALE_RESET;
    logic [bds_pkg::OW_W-1:0]    cfg_width = bds_pkg::OUT_WIDTH_RESET;
    bds_pkg::entry_t             line_sums [bds_pkg::LINE_DEPTH];
    logic [1:0]                  blk_col = '0;
    logic [1:0]                  blk_row = '0;
    bds_pkg::col_t               sum_col = '0;

    src_pix_t src_pixels [$];
    dst_pix_t due_pixels [$];
    src_pix_t nxt_src;
    dst_pix_t due_now;

    int  n_pushed = 0;
    int  n_taken = 0;
    int  n_errors = 0;
    int  in_gap = 0;
    int  stall_left = 0;
    int  hold_reqs = 0;
    int  holds_served = 0;
    int  idle_cycles = 0;
    bit  in_idle_on = 1'b0;
    bit  out_idle_on = 1'b0;

    box_downscale_rgb555 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .first     (first),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel),
        .row_end   (row_end)
    );

    function automatic int eff_scale(input logic [bds_pkg::SCALE_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > 4)
            return 4;
        return int'(raw);
    endfunction

    function automatic int eff_width(input logic [bds_pkg::OW_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > bds_pkg::LINE_DEPTH)
            return bds_pkg::LINE_DEPTH;
        return int'(raw);
    endfunction

    function automatic logic [bds_pkg::CH_W-1:0] box_mean(input logic [bds_pkg::SUM_W-1:0] sum,
                                                          input int s);
        logic [bds_pkg::SUM_W-1:0] q;
        if (s == 2)
            q = sum >> 2;
        else if (s == 3)
            q = sum / 9;
        else
            q = sum >> 4;
        return q[bds_pkg::CH_W-1:0];
    endfunction

    function automatic logic [bds_pkg::PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // advance the shadow state by one source pixel, queue the output pixel if one is due
    task automatic downscale_step(input logic [bds_pkg::PIX_W-1:0] pix, input logic restart);
        int                        s;
        int                        w;
        bds_pkg::entry_t           ent;
        logic [bds_pkg::SUM_W-1:0] b;
        logic [bds_pkg::SUM_W-1:0] g;
        logic [bds_pkg::SUM_W-1:0] r;
        logic                      lc;
        logic                      lr;
        logic                      at_end;
        dst_pix_t                  d;
        s = eff_scale(cfg_scale);
        w = eff_width(cfg_width);
        if (restart)
        begin
            blk_col = '0;
            blk_row = '0;
            sum_col = '0;
        end
        if (sum_col > w - 1)
            sum_col = bds_pkg::col_t'(w - 1);
        if (blk_col > s - 1)
            blk_col = 2'(s - 1);
        if (blk_row > s - 1)
            blk_row = 2'(s - 1);
        at_end = (sum_col == w - 1);
        if (s == 1)
        begin
            d.pix = pix;
            d.row_end = at_end;
            due_pixels.push_back(d);
            sum_col = at_end ? '0 : sum_col + 1'b1;
            blk_col = '0;
            blk_row = '0;
        end
        else
        begin
            ent = (blk_row == 0 && blk_col == 0) ? '0 : line_sums[sum_col];
            b = ent[8:0] + pix[4:0];
            g = ent[17:9] + pix[9:5];
            r = ent[26:18] + pix[14:10];
            line_sums[sum_col] = {r, g, b};
            lc = (blk_col == s - 1);
            lr = (blk_row == s - 1);
            if (lc && lr)
            begin
                d.pix = {1'b1, box_mean(r, s), box_mean(g, s), box_mean(b, s)};
                d.row_end = at_end;
                due_pixels.push_back(d);
            end
            if (lc)
            begin
                blk_col = '0;
                if (at_end)
                begin
                    sum_col = '0;
                    blk_row = lr ? 2'd0 : blk_row + 1'b1;
                end
                else
                begin
                    sum_col = sum_col + 1'b1;
                end
            end
            else
            begin
                blk_col = blk_col + 1'b1;
            end
        end
    endtask

    task automatic offer(input logic [bds_pkg::PIX_W-1:0] p, input logic restart);
        src_pixels.push_back('{pix: p, first: restart});
        n_pushed++;
    endtask

    task automatic offer_run(input logic [bds_pkg::PIX_W-1:0] p, input int n,
                             input logic restart);
        for (int i = 0; i < n; i++)
            offer(p, restart && i == 0);
    endtask

    task automatic offer_rand(input int n, input logic restart);
        for (int i = 0; i < n; i++)
            offer(rand_pix(), restart && i == 0);
    endtask

    // one region of brows block rows; a broken one is cut short or restarted midway
    task automatic send_region(input int s, input int w, input int brows,
                               input logic restart, input bit broken);
        int total;
        int cut;
        int jolt;
        total = w * s * s * brows;
        cut = total;
        jolt = -1;
        if (broken)
        begin
            if ($urandom_range(0, 1))
                cut = $urandom_range(1, total);
            else
                jolt = $urandom_range(1, total);
        end
        for (int i = 0; i < cut; i++)
            offer(rand_pix(), (restart && i == 0) || i == jolt);
    endtask

    task automatic drain();
        while (n_taken != n_pushed || due_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [bds_pkg::APB_AW-1:0] addr,
                             input logic [bds_pkg::APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == bds_pkg::ADDR_SCALE)
            cfg_scale = data[bds_pkg::SCALE_W-1:0];
        else if (addr == bds_pkg::ADDR_OUT_WIDTH)
            cfg_width = data[bds_pkg::OW_W-1:0];
    endtask

    task automatic set_format(input int s, input int w);
        drain();
        reg_write(bds_pkg::ADDR_SCALE, bds_pkg::APB_DW'(s));
        reg_write(bds_pkg::ADDR_OUT_WIDTH, bds_pkg::APB_DW'(w));
    endtask

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel <= '0;
            first <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                downscale_step(pixel, first);
                n_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (src_pixels.size() > 0)
                begin
                    nxt_src = src_pixels.pop_front();
                    pixel <= nxt_src.pix;
                    first <= nxt_src.first;
                    in_valid <= 1'b1;
                    in_gap = in_idle_on ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (holds_served != hold_reqs)
            begin
                holds_served = hold_reqs;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = out_idle_on ? pick_gap() : 0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_pixels.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, got pixel %h row_end %b",
                         $time, out_pixel, row_end);
                n_errors++;
            end
            else
            begin
                due_now = due_pixels.pop_front();
                if (out_pixel !== due_now.pix)
                begin
                    $display("%0t: out_pixel expected %h got %h",
                             $time, due_now.pix, out_pixel);
                    n_errors++;
                end
                if (row_end !== due_now.row_end)
                begin
                    $display("%0t: row_end expected %b got %b",
                             $time, due_now.row_end, row_end);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int raw_s;
        int raw_w;
        int s_eff;
        int w_eff;
        int brows;
        int n_before;
        int n_random;
        bit clean;
        bit broken;
        for (int i = 0; i < bds_pkg::LINE_DEPTH; i++)
            line_sums[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: pass-through, row far from its end
        offer(16'h0000, 1'b1);
        offer(16'hffff, 1'b0);
        offer(16'h7fff, 1'b0);
        offer(16'h8000, 1'b0);

        // zero scale and zero width act as one
        set_format(0, 0);
        offer_rand(3, 1'b1);

        // bit 15 of the source is dropped when averaging
        set_format(2, 1);
        offer(16'h7fff, 1'b1);
        offer_run(16'hffff, 3, 1'b0);
        offer_run(16'h8000, 4, 1'b0);

        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        set_format(3, 1);
        offer_run(16'h7fff, 9, 1'b1);

        // scale above four acts as four
        set_format(7, 1);
        offer_run(16'hffff, 16, 1'b1);

        // width shrunk mid-region: column clamps onto a full entry, sums wrap
        set_format(4, 2);
        offer_run(16'h7fff, 28, 1'b1);
        drain();
        reg_write(bds_pkg::ADDR_OUT_WIDTH, bds_pkg::APB_DW'(1));
        offer_run(16'h7fff, 4, 1'b0);

        // scale shrunk mid-block: both block counters clamp to last position
        set_format(4, 1);
        offer_rand(10, 1'b1);
        drain();
        reg_write(bds_pkg::ADDR_SCALE, bds_pkg::APB_DW'(2));
        offer(16'h7fff, 1'b0);

        // long sink hold while the source keeps streaming
        set_format(1, 5);
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        send_region(1, 5, 16, 1'b1, 1'b0);
        @(posedge clk);
        hold_reqs <= hold_reqs + 1;

        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        set_format(1, 1024);
        offer_rand(40, 1'b1);

        // width above the line store depth clamps to it
        set_format(1, 1025);
        offer_rand(40, 1'b1);

        n_random = 0;
        clean = 1'b0;
        while (n_random < RANDOM_ITEMS)
        begin
            in_idle_on = $urandom_range(0, 3) != 0;
            out_idle_on = $urandom_range(0, 3) != 0;
            if (n_random == 0 || $urandom_range(0, 2) == 0)
            begin
                raw_s = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0:       raw_w = 0;
                    1, 2:    raw_w = $urandom_range(7, 24);
                    default: raw_w = $urandom_range(1, 6);
                endcase
                set_format(raw_s, raw_w);
            end
            s_eff = eff_scale(cfg_scale);
            w_eff = eff_width(cfg_width);
            brows = (w_eff * s_eff * s_eff > 64) ? 1 : $urandom_range(1, 3);
            broken = $urandom_range(0, 7) == 0;
            n_before = n_pushed;
            send_region(s_eff, w_eff, brows, !clean || $urandom_range(0, 1), broken);
            n_random += n_pushed - n_before;
            clean = !broken;
        end

        while (n_taken != n_pushed || due_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
